// File: src/lfsm_pkg.sv
package lfsm_pkg;

   typedef enum logic [2:0] {
      OP_BEGIN_WRITE = 3'd0,
      OP_END_WRITE   = 3'd1,
      OP_BEGIN_READ  = 3'd2,
      OP_END_READ    = 3'd3,
      OP_QUERY       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      RES_DONE           = 2'd0,
      RES_SIZE_REJECTED  = 2'd1,
      RES_NO_SLOT_OPEN   = 2'd2,
      RES_NO_READY_FRAME = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_WRITING = 2'd1,
      SLOT_READY   = 2'd2,
      SLOT_READING = 2'd3
   } slot_state_type;

   typedef enum logic [0:0] {
      CSR_MAX_WIDTH  = 1'b0,
      CSR_MAX_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [12:0] MAX_WIDTH_RESET  = 13'd1920;
   localparam logic [12:0] MAX_HEIGHT_RESET = 13'd1080;

   typedef struct packed {
      op_type      op;
      logic [12:0] width;
      logic [12:0] height;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot_index;
      logic [29:0] pixel_offset;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [14:0] row_stride;
      logic        any_ready;
      logic [31:0] frames_written;
   } rsp_type;

   // result of the newest-ready search
   typedef struct packed {
      logic       found;
      logic [2:0] slot;
   } pick_type;

endpackage

// File: src/lfsm_newest_ready.sv
module lfsm_newest_ready #(
   parameter int NUM_SLOTS = 3
) (
   input  logic [NUM_SLOTS-1:0]                 ready_mask,
   input  logic [$clog2(NUM_SLOTS)-1:0]         write_ptr,
   output lfsm_pkg::pick_type                   pick
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);

   // walk from the oldest candidate to the newest so the newest ready slot wins
   always_comb begin
      logic [SLOT_W:0] idx;
      pick = '0;
      for (int k = NUM_SLOTS; k >= 1; k--) begin
         idx = {1'b0, write_ptr} + (SLOT_W+1)'(NUM_SLOTS - k);
         if (idx >= (SLOT_W+1)'(NUM_SLOTS)) begin
            idx = idx - (SLOT_W+1)'(NUM_SLOTS);
         end
         if (ready_mask[idx[SLOT_W-1:0]]) begin
            pick.found = 1'b1;
            pick.slot  = 3'(idx[SLOT_W-1:0]);
         end
      end
   end

endmodule

// File: src/latest_frame_slot_manager_unit.sv
// Path: an accepted word moves from the request register to the result register
// (two-register path), waiting in the request register while the result is stalled.
// Throughput: one word per cycle; the request register refills in the same cycle
// its word moves on, so only a stalled result holds the input back.
// Reset (synchronous, active high): all slots empty, pointers and frame count
// zero, limits back to 1920 x 1080, both channels empty.
module latest_frame_slot_manager_unit #(
   parameter int NUM_SLOTS         = 3,
   parameter int BYTES_PER_PIXEL   = 4,
   parameter int SLOT_HEADER_BYTES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lfsm_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lfsm_pkg::rsp_type       rsp_data,
   input  logic                    csr_wr_en,
   input  lfsm_pkg::csr_index_type csr_index,
   input  logic [12:0]             csr_wdata
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [29:0] PITCH_RESET =
      30'(lfsm_pkg::MAX_WIDTH_RESET) * 30'(lfsm_pkg::MAX_HEIGHT_RESET)
      * 30'(BYTES_PER_PIXEL) + 30'(SLOT_HEADER_BYTES);

   logic [12:0] max_width_ff, max_height_ff;
   logic [12:0] max_width_in, max_height_in;
   logic [29:0] pitch_ff, pitch_in;

   logic              in_valid_ff, in_valid_in;
   lfsm_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   lfsm_pkg::rsp_type out_data_ff, out_data_in;
   logic              advance, req_fire;

   lfsm_pkg::slot_state_type slot_state_ff [NUM_SLOTS];
   lfsm_pkg::slot_state_type slot_state_in [NUM_SLOTS];
   logic [12:0]       slot_width_ff [NUM_SLOTS];
   logic [12:0]       slot_width_in [NUM_SLOTS];
   logic [12:0]       slot_height_ff [NUM_SLOTS];
   logic [12:0]       slot_height_in [NUM_SLOTS];
   logic [SLOT_W-1:0] write_ptr_ff, write_ptr_in;
   logic [31:0]       frame_count_ff, frame_count_in;
   logic              open_wr_valid_ff, open_wr_valid_in;
   logic [SLOT_W-1:0] open_wr_slot_ff, open_wr_slot_in;
   logic              open_rd_valid_ff, open_rd_valid_in;
   logic [SLOT_W-1:0] open_rd_slot_ff, open_rd_slot_in;

   logic [NUM_SLOTS-1:0] ready_mask;
   lfsm_pkg::pick_type   pick;
   logic [SLOT_W-1:0]    pick_slot, claim_slot;
   logic [29:0]          claim_offset;

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_comb begin
      max_width_in  = max_width_ff;
      max_height_in = max_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lfsm_pkg::CSR_MAX_WIDTH:  max_width_in  = csr_wdata;
            lfsm_pkg::CSR_MAX_HEIGHT: max_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // slot pitch is registered together with the limits
   assign pitch_in = 30'(max_width_in) * 30'(max_height_in) * 30'(BYTES_PER_PIXEL)
                     + 30'(SLOT_HEADER_BYTES);

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         ready_mask[i] = (slot_state_ff[i] == lfsm_pkg::SLOT_READY);
      end
   end

   lfsm_newest_ready #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_newest_ready (
      .ready_mask (ready_mask),
      .write_ptr  (write_ptr_ff),
      .pick       (pick)
   );

   assign pick_slot    = SLOT_W'(pick.slot);
   assign claim_slot   = (in_data_ff.op == lfsm_pkg::OP_BEGIN_READ) ? pick_slot : write_ptr_ff;
   assign claim_offset = 30'(claim_slot) * pitch_ff + 30'(SLOT_HEADER_BYTES);

   always_comb begin
      slot_state_in    = slot_state_ff;
      slot_width_in    = slot_width_ff;
      slot_height_in   = slot_height_ff;
      write_ptr_in     = write_ptr_ff;
      frame_count_in   = frame_count_ff;
      open_wr_valid_in = open_wr_valid_ff;
      open_wr_slot_in  = open_wr_slot_ff;
      open_rd_valid_in = open_rd_valid_ff;
      open_rd_slot_in  = open_rd_slot_ff;
      out_data_in      = '0;
      out_data_in.status = lfsm_pkg::RES_DONE;

      case (in_data_ff.op)
         lfsm_pkg::OP_BEGIN_WRITE: begin
            if (in_data_ff.width > max_width_ff || in_data_ff.height > max_height_ff) begin
               out_data_in.status = lfsm_pkg::RES_SIZE_REJECTED;
            end else begin
               slot_state_in[write_ptr_ff]  = lfsm_pkg::SLOT_WRITING;
               slot_width_in[write_ptr_ff]  = in_data_ff.width;
               slot_height_in[write_ptr_ff] = in_data_ff.height;
               write_ptr_in     = (write_ptr_ff == LAST_SLOT) ? '0 : write_ptr_ff + SLOT_W'(1);
               open_wr_valid_in = 1'b1;
               open_wr_slot_in  = write_ptr_ff;
               out_data_in.slot_index   = 3'(write_ptr_ff);
               out_data_in.pixel_offset = claim_offset;
               out_data_in.frame_width  = in_data_ff.width;
               out_data_in.frame_height = in_data_ff.height;
               out_data_in.row_stride   = 15'(in_data_ff.width) * 15'(BYTES_PER_PIXEL);
            end
         end
         lfsm_pkg::OP_END_WRITE: begin
            if (!open_wr_valid_ff) begin
               out_data_in.status = lfsm_pkg::RES_NO_SLOT_OPEN;
            end else begin
               slot_state_in[open_wr_slot_ff] = lfsm_pkg::SLOT_READY;
               frame_count_in   = frame_count_ff + 32'd1;
               open_wr_valid_in = 1'b0;
               out_data_in.slot_index = 3'(open_wr_slot_ff);
            end
         end
         lfsm_pkg::OP_BEGIN_READ: begin
            if (!pick.found) begin
               out_data_in.status = lfsm_pkg::RES_NO_READY_FRAME;
            end else begin
               slot_state_in[pick_slot] = lfsm_pkg::SLOT_READING;
               open_rd_valid_in = 1'b1;
               open_rd_slot_in  = pick_slot;
               out_data_in.slot_index   = pick.slot;
               out_data_in.pixel_offset = claim_offset;
               out_data_in.frame_width  = slot_width_ff[pick_slot];
               out_data_in.frame_height = slot_height_ff[pick_slot];
               out_data_in.row_stride   = 15'(slot_width_ff[pick_slot]) * 15'(BYTES_PER_PIXEL);
            end
         end
         lfsm_pkg::OP_END_READ: begin
            if (!open_rd_valid_ff) begin
               out_data_in.status = lfsm_pkg::RES_NO_SLOT_OPEN;
            end else begin
               slot_state_in[open_rd_slot_ff] = lfsm_pkg::SLOT_EMPTY;
               open_rd_valid_in = 1'b0;
               out_data_in.slot_index = 3'(open_rd_slot_ff);
            end
         end
         default: begin
            // query and unused codes: report only
         end
      endcase

      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_state_in[i] == lfsm_pkg::SLOT_READY) begin
            out_data_in.any_ready = 1'b1;
         end
      end
      out_data_in.frames_written = frame_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff     <= lfsm_pkg::MAX_WIDTH_RESET;
         max_height_ff    <= lfsm_pkg::MAX_HEIGHT_RESET;
         pitch_ff         <= PITCH_RESET;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         write_ptr_ff     <= '0;
         frame_count_ff   <= '0;
         open_wr_valid_ff <= 1'b0;
         open_wr_slot_ff  <= '0;
         open_rd_valid_ff <= 1'b0;
         open_rd_slot_ff  <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state_ff[i]  <= lfsm_pkg::SLOT_EMPTY;
            slot_width_ff[i]  <= '0;
            slot_height_ff[i] <= '0;
         end
      end else begin
         max_width_ff  <= max_width_in;
         max_height_ff <= max_height_in;
         pitch_ff      <= pitch_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         if (advance) begin
            slot_state_ff    <= slot_state_in;
            slot_width_ff    <= slot_width_in;
            slot_height_ff   <= slot_height_in;
            write_ptr_ff     <= write_ptr_in;
            frame_count_ff   <= frame_count_in;
            open_wr_valid_ff <= open_wr_valid_in;
            open_wr_slot_ff  <= open_wr_slot_in;
            open_rd_valid_ff <= open_rd_valid_in;
            open_rd_slot_ff  <= open_rd_slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// File: src/lfsm_checker.sv
module lfsm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lfsm_pkg::rsp_type rsp_data
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // input is only held back by a stalled result
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with result side free");

   // every accepted word is followed by a valid result word (its own or a stalled older one)
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("accepted word produced no result");

   // failed operations report no slot data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != lfsm_pkg::RES_DONE |->
         rsp_data.slot_index == 3'd0 && rsp_data.pixel_offset == 30'd0 &&
         rsp_data.frame_width == 13'd0 && rsp_data.frame_height == 13'd0 &&
         rsp_data.row_stride == 15'd0)
      else $error("failed operation carries slot data");

endmodule

bind latest_frame_slot_manager_unit lfsm_checker u_lfsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS         = 3;
   localparam int BYTES_PER_PIXEL   = 4;
   localparam int SLOT_HEADER_BYTES = 16;
   localparam int HOLD_CYCLES       = 60;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int DRAIN_CYCLES      = 4;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   lfsm_pkg::req_type       req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   lfsm_pkg::rsp_type       rsp_data;
   logic                    csr_wr_en = 1'b0;
   lfsm_pkg::csr_index_type csr_index = lfsm_pkg::CSR_MAX_WIDTH;
   logic [12:0]             csr_wdata = '0;

   latest_frame_slot_manager_unit #(
      .NUM_SLOTS(NUM_SLOTS),
      .BYTES_PER_PIXEL(BYTES_PER_PIXEL),
      .SLOT_HEADER_BYTES(SLOT_HEADER_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow of the slot ring
   lfsm_pkg::slot_state_type ring_state [NUM_SLOTS];
   logic [12:0]    ring_width [NUM_SLOTS];
   logic [12:0]    ring_height[NUM_SLOTS];
   int             wr_ptr;
   bit             wr_open;
   int             wr_slot;
   bit             rd_open;
   int             rd_slot;
   logic [31:0]    done_frames;
   logic [12:0]    lim_w;
   logic [12:0]    lim_h;

   lfsm_pkg::rsp_type pending_responses[$];
   int      failures = 0;
   int      cycle_count = 0;
   bit      no_idle = 1'b0;
   bit      hold_off_request = 1'b0;
   bit      hold_active = 1'b0;

   task automatic reset_shadow();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         ring_state[i]  = lfsm_pkg::SLOT_EMPTY;
         ring_width[i]  = '0;
         ring_height[i] = '0;
      end
      wr_ptr      = 0;
      wr_open     = 1'b0;
      wr_slot     = 0;
      rd_open     = 1'b0;
      rd_slot     = 0;
      done_frames = '0;
      lim_w       = lfsm_pkg::MAX_WIDTH_RESET;
      lim_h       = lfsm_pkg::MAX_HEIGHT_RESET;
   endtask

   function automatic void claim_fields(ref lfsm_pkg::rsp_type r, input int s);
      longint unsigned off;
      off = longint'(s) * (SLOT_HEADER_BYTES + longint'(lim_w) * longint'(lim_h)
            * BYTES_PER_PIXEL) + SLOT_HEADER_BYTES;
      r.slot_index   = 3'(s);
      r.pixel_offset = off[29:0];
      r.frame_width  = ring_width[s];
      r.frame_height = ring_height[s];
      r.row_stride   = 15'(int'(ring_width[s]) * BYTES_PER_PIXEL);
   endfunction

   function automatic lfsm_pkg::rsp_type frame_slot_predict(lfsm_pkg::req_type w);
      lfsm_pkg::rsp_type r;
      int      s;
      bit      found;
      r = '0;
      r.status = lfsm_pkg::RES_DONE;
      case (w.op)
         lfsm_pkg::OP_BEGIN_WRITE: begin
            if (w.width > lim_w || w.height > lim_h) begin
               r.status = lfsm_pkg::RES_SIZE_REJECTED;
            end else begin
               s = wr_ptr;
               ring_state[s]  = lfsm_pkg::SLOT_WRITING;
               ring_width[s]  = w.width;
               ring_height[s] = w.height;
               wr_ptr  = (s + 1) % NUM_SLOTS;
               wr_open = 1'b1;
               wr_slot = s;
               claim_fields(r, s);
            end
         end
         lfsm_pkg::OP_END_WRITE: begin
            if (!wr_open) begin
               r.status = lfsm_pkg::RES_NO_SLOT_OPEN;
            end else begin
               ring_state[wr_slot] = lfsm_pkg::SLOT_READY;
               done_frames = done_frames + 1;
               wr_open = 1'b0;
               r.slot_index = 3'(wr_slot);
            end
         end
         lfsm_pkg::OP_BEGIN_READ: begin
            found = 1'b0;
            // newest first: walk back from the slot before the write pointer
            for (int k = 1; k <= NUM_SLOTS && !found; k++) begin
               s = (wr_ptr + NUM_SLOTS - k) % NUM_SLOTS;
               if (ring_state[s] == lfsm_pkg::SLOT_READY) begin
                  ring_state[s] = lfsm_pkg::SLOT_READING;
                  rd_open = 1'b1;
                  rd_slot = s;
                  claim_fields(r, s);
                  found = 1'b1;
               end
            end
            if (!found) r.status = lfsm_pkg::RES_NO_READY_FRAME;
         end
         lfsm_pkg::OP_END_READ: begin
            if (!rd_open) begin
               r.status = lfsm_pkg::RES_NO_SLOT_OPEN;
            end else begin
               ring_state[rd_slot] = lfsm_pkg::SLOT_EMPTY;
               rd_open = 1'b0;
               r.slot_index = 3'(rd_slot);
            end
         end
         default: ;
      endcase
      r.any_ready = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (ring_state[i] == lfsm_pkg::SLOT_READY) r.any_ready = 1'b1;
      r.frames_written = done_frames;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic lfsm_pkg::req_type req_word(logic [2:0] code, logic [12:0] w,
                                                  logic [12:0] h);
      lfsm_pkg::req_type r;
      r.op     = lfsm_pkg::op_type'(code);
      r.width  = w;
      r.height = h;
      return r;
   endfunction

   function automatic logic [12:0] rand_dim(logic [12:0] limit);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return 13'($urandom_range(0, limit));
      if (roll < 8) return (limit < 4096) ? 13'($urandom_range(limit + 1, 4096)) : 13'd4096;
      case ($urandom_range(0, 2))
         0: return 13'd0;
         1: return limit;
         default: return 13'd4096;
      endcase
   endfunction

   function automatic logic [12:0] junk_dim();
      return 13'($urandom_range(0, 4096));
   endfunction

   // returns in the time step at which the word was taken; valid stays up
   task automatic send_word(lfsm_pkg::req_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_responses.push_back(frame_slot_predict(w));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_limits(logic [12:0] w, logic [12:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= lfsm_pkg::CSR_MAX_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      lim_w = w;
      csr_index <= lfsm_pkg::CSR_MAX_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      lim_h = h;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_traffic(int count);
      int sent;
      int kind;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, rand_dim(lim_w), rand_dim(lim_h)));
            send_word(req_word(lfsm_pkg::OP_END_WRITE, junk_dim(), junk_dim()));
            sent += 2;
         end else if (kind < 7) begin
            send_word(req_word(lfsm_pkg::OP_BEGIN_READ, junk_dim(), junk_dim()));
            send_word(req_word(lfsm_pkg::OP_END_READ, junk_dim(), junk_dim()));
            sent += 2;
         end else if (kind == 7) begin
            send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, rand_dim(lim_w), rand_dim(lim_h)));
            send_word(req_word(lfsm_pkg::OP_BEGIN_READ, junk_dim(), junk_dim()));
            send_word(req_word(lfsm_pkg::OP_END_WRITE, junk_dim(), junk_dim()));
            send_word(req_word(lfsm_pkg::OP_END_READ, junk_dim(), junk_dim()));
            sent += 4;
         end else begin
            send_word(req_word(3'($urandom_range(0, 7)), rand_dim(lim_w), rand_dim(lim_h)));
            sent += 1;
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_word(req_word(lfsm_pkg::OP_QUERY, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_END_WRITE, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_END_READ, 13'd4096, 13'd4096));
      send_word(req_word(lfsm_pkg::OP_BEGIN_READ, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd1921, 13'd1080));
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd1920, 13'd1081));
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd1920, 13'd1080));
      send_word(req_word(lfsm_pkg::OP_END_WRITE, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_BEGIN_READ, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_END_READ, 13'd0, 13'd0));
      send_word(req_word(OP_UNUSED_LO, 13'd4095, 13'd4095));
      send_word(req_word(OP_UNUSED_HI, 13'd4096, 13'd0));
      drain();
   endtask

   task automatic test_slot_reuse();
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_END_WRITE, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_BEGIN_READ, 13'd0, 13'd0));
      // second begin-write while one is still open
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd640, 13'd480));
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd800, 13'd600));
      send_word(req_word(lfsm_pkg::OP_END_WRITE, 13'd0, 13'd0));
      // writer laps onto the slot being read
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd1024, 13'd768));
      send_word(req_word(lfsm_pkg::OP_END_READ, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_BEGIN_READ, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_BEGIN_READ, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_END_WRITE, 13'd0, 13'd0));
      drain();
   endtask

   task automatic test_limit_extremes();
      write_limits(13'd1, 13'd1);
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd1, 13'd1));
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd2, 13'd1));
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd1, 13'd2));
      send_word(req_word(lfsm_pkg::OP_END_WRITE, 13'd0, 13'd0));
      drain();
      write_limits(13'd4096, 13'd4096);
      send_word(req_word(lfsm_pkg::OP_BEGIN_WRITE, 13'd4096, 13'd4096));
      send_word(req_word(lfsm_pkg::OP_END_WRITE, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_BEGIN_READ, 13'd0, 13'd0));
      send_word(req_word(lfsm_pkg::OP_END_READ, 13'd0, 13'd0));
      drain();
   endtask

   task automatic test_input_stall();
      write_limits(lfsm_pkg::MAX_WIDTH_RESET, lfsm_pkg::MAX_HEIGHT_RESET);
      hold_off_request = 1'b1;
      while (!hold_active) @(posedge clock);
      no_idle = 1'b1;
      send_random_traffic(24);
      no_idle = 1'b0;
      drain();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_limits(13'd1, 13'd1);
            1: write_limits(lfsm_pkg::MAX_WIDTH_RESET, lfsm_pkg::MAX_HEIGHT_RESET);
            2: write_limits(13'd4096, 13'd4096);
            default: write_limits(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
         endcase
         if (phase == 2) begin
            no_idle = 1'b1;
            send_random_traffic(120);
            no_idle = 1'b0;
            send_random_traffic(155);
         end else begin
            send_random_traffic(275);
         end
         drain();
      end
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      lfsm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            $error("result word with nothing pending, status %0d", rsp_data.status);
            failures++;
         end else begin
            want = pending_responses.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("slot_index", want.slot_index, rsp_data.slot_index);
            check_field("pixel_offset", want.pixel_offset, rsp_data.pixel_offset);
            check_field("frame_width", want.frame_width, rsp_data.frame_width);
            check_field("frame_height", want.frame_height, rsp_data.frame_height);
            check_field("row_stride", want.row_stride, rsp_data.row_stride);
            check_field("any_ready", want.any_ready, rsp_data.any_ready);
            check_field("frames_written", want.frames_written, rsp_data.frames_written);
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_slot_reuse();
      test_limit_extremes();
      test_input_stall();
      test_random_traffic();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0) begin
         $error("%0d result words never arrived", pending_responses.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/lfsm_pkg.sv
src/lfsm_newest_ready.sv
src/latest_frame_slot_manager_unit.sv
src/lfsm_checker.sv
test/testbench.sv
